### rtl/core/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int OFF_W     = 25;
	localparam int SIZE_W    = 26;
	localparam int HDR_BYTES = 16;

	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [SIZE_W-1:0] size_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_NO_MEMORY = 3'd2,
		ST_FREE_FULL = 3'd3,
		ST_UNKNOWN   = 3'd4,
		ST_LIVE_FULL = 3'd5
	} status_t;

	// header offset (free table) or payload offset (live table), and payload size
	typedef struct packed {
		off_t start;
		off_t len;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_A_SLOT,
		S_A_RD,
		S_A_CMP,
		S_SH_RD,
		S_SH_WR,
		S_F_LIVE,
		S_F_LCMP,
		S_F_RD,
		S_F_CMP,
		S_F_DEC,
		S_U_RD,
		S_U_WR
	} fsm_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ERR,
		OP_NEXT,
		OP_SLOT,
		OP_FRD,
		OP_ASPLIT,
		OP_ATAKE,
		OP_SHRD,
		OP_SHWR,
		OP_SHFIN,
		OP_LRD,
		OP_LHIT,
		OP_PREV,
		OP_POSHIT,
		OP_MBOTH,
		OP_MPREV,
		OP_MNEXT,
		OP_INSPREP,
		OP_URD,
		OP_UWR,
		OP_INS
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t err;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic live_end;
		logic slot_open;
		logic slot_valid;
		logic free_end;
		logic fit;
		logic split;
		logic live_hit;
		logic pos_hit;
		logic merge_prev;
		logic merge_next;
		logic table_full;
		logic shift_last;
		logic up_done;
	} dp_flags_t;

endpackage

### rtl/core/first_fit_heap_allocator.sv
// each item walks the tables; a shift reads and then writes each moved entry,
// a table walk reads each entry and may compare it in a separate state
// throughput: one item at a time, busy stays high until the result strobe
// the result shows for one cycle with done; the receiver cannot stall it
// reset: free table holds one extent of arena minus header, no live allocations
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
	parameter int PAGE_BYTES       = 4096,
	parameter int PAGE_COUNT       = 8192,
	parameter int MAX_FREE_EXTENTS = 256,
	parameter int MAX_LIVE_ALLOCS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [25:0] request_size,
	input  logic [24:0] release_offset,
	output logic        done,
	output logic [2:0]  status,
	output logic [24:0] payload_offset,
	output logic [25:0] granted_size,
	output logic [25:0] free_bytes
);

	// command and status between sequencer and datapath
	ffha_pkg::dp_cmd_t   cmd;
	ffha_pkg::dp_flags_t flags;

	// sequencer: walks the live table, then the sorted free table, then shifts
	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: both tables as memories with separate read and write ports, running free byte total
	ffha_dp #(
		.PAGE_BYTES       (PAGE_BYTES),
		.PAGE_COUNT       (PAGE_COUNT),
		.MAX_FREE_EXTENTS (MAX_FREE_EXTENTS),
		.MAX_LIVE_ALLOCS  (MAX_LIVE_ALLOCS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.request_size   (request_size),
		.release_offset (release_offset),
		.flags          (flags),
		.done           (done),
		.status         (status),
		.payload_offset (payload_offset),
		.granted_size   (granted_size),
		.free_bytes     (free_bytes)
	);

endmodule

### rtl/core/ffha_ctrl.sv
// sequencer for the allocator: walks tables and issues datapath commands
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ffha_pkg::dp_flags_t flags,
	output ffha_pkg::dp_cmd_t   cmd,
	output logic                busy
);

	ffha_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (start) state_d = ffha_pkg::S_CHK;
			end
			ffha_pkg::S_CHK: begin
				if (flags.is_free) state_d = ffha_pkg::S_F_LIVE;
				else if (flags.req_zero) state_d = ffha_pkg::S_IDLE;
				else state_d = ffha_pkg::S_A_SLOT;
			end
			ffha_pkg::S_A_SLOT: begin
				if (flags.live_end) state_d = ffha_pkg::S_IDLE;
				else if (flags.slot_open) state_d = ffha_pkg::S_A_RD;
			end
			ffha_pkg::S_A_RD: begin
				state_d = flags.free_end ? ffha_pkg::S_IDLE : ffha_pkg::S_A_CMP;
			end
			ffha_pkg::S_A_CMP: begin
				if (flags.fit && flags.split) state_d = ffha_pkg::S_IDLE;
				else if (flags.fit) state_d = ffha_pkg::S_SH_RD;
				else state_d = ffha_pkg::S_A_RD;
			end
			ffha_pkg::S_SH_RD: begin
				state_d = flags.shift_last ? ffha_pkg::S_IDLE : ffha_pkg::S_SH_WR;
			end
			ffha_pkg::S_SH_WR: state_d = ffha_pkg::S_SH_RD;
			ffha_pkg::S_F_LIVE: begin
				if (flags.live_end) state_d = ffha_pkg::S_IDLE;
				else if (flags.slot_valid) state_d = ffha_pkg::S_F_LCMP;
			end
			ffha_pkg::S_F_LCMP: begin
				state_d = flags.live_hit ? ffha_pkg::S_F_RD : ffha_pkg::S_F_LIVE;
			end
			ffha_pkg::S_F_RD: begin
				state_d = flags.free_end ? ffha_pkg::S_F_DEC : ffha_pkg::S_F_CMP;
			end
			ffha_pkg::S_F_CMP: begin
				state_d = flags.pos_hit ? ffha_pkg::S_F_DEC : ffha_pkg::S_F_RD;
			end
			ffha_pkg::S_F_DEC: begin
				if (flags.merge_prev && flags.merge_next) state_d = ffha_pkg::S_SH_RD;
				else if (flags.merge_prev || flags.merge_next) state_d = ffha_pkg::S_IDLE;
				else if (flags.table_full) state_d = ffha_pkg::S_IDLE;
				else state_d = ffha_pkg::S_U_RD;
			end
			ffha_pkg::S_U_RD: begin
				state_d = flags.up_done ? ffha_pkg::S_IDLE : ffha_pkg::S_U_WR;
			end
			ffha_pkg::S_U_WR: state_d = ffha_pkg::S_U_RD;
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.op  = ffha_pkg::OP_NONE;
		cmd.err = ffha_pkg::ST_OK;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (start) cmd.op = ffha_pkg::OP_LOAD;
			end
			ffha_pkg::S_CHK: begin
				if (!flags.is_free && flags.req_zero) begin
					cmd.op  = ffha_pkg::OP_ERR;
					cmd.err = ffha_pkg::ST_ZERO_SIZE;
				end
			end
			ffha_pkg::S_A_SLOT: begin
				if (flags.live_end) begin
					cmd.op  = ffha_pkg::OP_ERR;
					cmd.err = ffha_pkg::ST_LIVE_FULL;
				end else if (flags.slot_open) begin
					cmd.op = ffha_pkg::OP_SLOT;
				end else begin
					cmd.op = ffha_pkg::OP_NEXT;
				end
			end
			ffha_pkg::S_A_RD: begin
				if (flags.free_end) begin
					cmd.op  = ffha_pkg::OP_ERR;
					cmd.err = ffha_pkg::ST_NO_MEMORY;
				end else begin
					cmd.op = ffha_pkg::OP_FRD;
				end
			end
			ffha_pkg::S_A_CMP: begin
				if (flags.fit && flags.split) cmd.op = ffha_pkg::OP_ASPLIT;
				else if (flags.fit) cmd.op = ffha_pkg::OP_ATAKE;
				else cmd.op = ffha_pkg::OP_NEXT;
			end
			ffha_pkg::S_SH_RD: begin
				cmd.op = flags.shift_last ? ffha_pkg::OP_SHFIN : ffha_pkg::OP_SHRD;
			end
			ffha_pkg::S_SH_WR: cmd.op = ffha_pkg::OP_SHWR;
			ffha_pkg::S_F_LIVE: begin
				if (flags.live_end) begin
					cmd.op  = ffha_pkg::OP_ERR;
					cmd.err = ffha_pkg::ST_UNKNOWN;
				end else if (flags.slot_valid) begin
					cmd.op = ffha_pkg::OP_LRD;
				end else begin
					cmd.op = ffha_pkg::OP_NEXT;
				end
			end
			ffha_pkg::S_F_LCMP: begin
				cmd.op = flags.live_hit ? ffha_pkg::OP_LHIT : ffha_pkg::OP_NEXT;
			end
			ffha_pkg::S_F_RD: begin
				if (!flags.free_end) cmd.op = ffha_pkg::OP_FRD;
			end
			ffha_pkg::S_F_CMP: begin
				cmd.op = flags.pos_hit ? ffha_pkg::OP_POSHIT : ffha_pkg::OP_PREV;
			end
			ffha_pkg::S_F_DEC: begin
				if (flags.merge_prev && flags.merge_next) begin
					cmd.op = ffha_pkg::OP_MBOTH;
				end else if (flags.merge_prev) begin
					cmd.op = ffha_pkg::OP_MPREV;
				end else if (flags.merge_next) begin
					cmd.op = ffha_pkg::OP_MNEXT;
				end else if (flags.table_full) begin
					cmd.op  = ffha_pkg::OP_ERR;
					cmd.err = ffha_pkg::ST_FREE_FULL;
				end else begin
					cmd.op = ffha_pkg::OP_INSPREP;
				end
			end
			ffha_pkg::S_U_RD: begin
				cmd.op = flags.up_done ? ffha_pkg::OP_INS : ffha_pkg::OP_URD;
			end
			ffha_pkg::S_U_WR: cmd.op = ffha_pkg::OP_UWR;
			default: cmd.op = ffha_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != ffha_pkg::S_IDLE);

endmodule

### rtl/core/ffha_dp.sv
// allocator datapath: free extent table, live table, counters and result registers
// depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_dp #(
	parameter int PAGE_BYTES       = 4096,
	parameter int PAGE_COUNT       = 8192,
	parameter int MAX_FREE_EXTENTS = 256,
	parameter int MAX_LIVE_ALLOCS  = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::dp_cmd_t   cmd,
	input  logic                opcode,
	input  ffha_pkg::size_t     request_size,
	input  ffha_pkg::off_t      release_offset,
	output ffha_pkg::dp_flags_t flags,
	output logic                done,
	output logic [2:0]          status,
	output ffha_pkg::off_t      payload_offset,
	output ffha_pkg::size_t     granted_size,
	output ffha_pkg::size_t     free_bytes
);

	localparam int OW   = ffha_pkg::OFF_W;
	localparam int SW   = ffha_pkg::SIZE_W;
	localparam int FAW  = $clog2(MAX_FREE_EXTENTS);
	localparam int LAW  = $clog2(MAX_LIVE_ALLOCS);
	localparam int FCW  = $clog2(MAX_FREE_EXTENTS + 1);
	localparam int MAXT = (MAX_FREE_EXTENTS > MAX_LIVE_ALLOCS) ?
		MAX_FREE_EXTENTS : MAX_LIVE_ALLOCS;
	localparam int IXW  = $clog2(MAXT + 1);
	localparam logic [63:0] ARENA = 64'(PAGE_BYTES) * 64'(PAGE_COUNT);
	localparam logic [63:0] INIT_FREE = ARENA - 64'(ffha_pkg::HDR_BYTES);
	localparam ffha_pkg::off_t  HDR = OW'(ffha_pkg::HDR_BYTES);
	localparam ffha_pkg::size_t HDR_S = SW'(ffha_pkg::HDR_BYTES);

	// memories
	ffha_pkg::entry_t fmem [MAX_FREE_EXTENTS];
	ffha_pkg::entry_t lmem [MAX_LIVE_ALLOCS];
	ffha_pkg::entry_t frd_q, lrd_q;
	logic             frd_zero_q;

	// control state
	logic [MAX_LIVE_ALLOCS-1:0] live_valid_q;
	logic [FCW-1:0]             count_q;
	ffha_pkg::size_t            total_q;
	logic                       e0_q;
	logic                       done_q;

	// working registers
	logic             opfree_q, reqz_q;
	logic [SW:0]      aligned_q;
	ffha_pkg::off_t   off_q, live_len_q;
	logic [IXW-1:0]   idx_q;
	logic [FCW-1:0]   jdx_q;
	logic [LAW-1:0]   slot_q;
	ffha_pkg::entry_t prev_q, cur_q;
	logic [2:0]       status_q;
	ffha_pkg::off_t   res_off_q;
	ffha_pkg::size_t  res_size_q;

	ffha_pkg::entry_t f;
	ffha_pkg::entry_t init_e;
	ffha_pkg::off_t   hdr;
	logic [FAW-1:0]   fr_addr, fw_addr;
	logic             fw_en, lw_en, fin, free_ok;
	ffha_pkg::entry_t fw_data, lw_data;
	logic [IXW-1:0]   idx_p1;

	assign init_e.start = '0;
	assign init_e.len   = OW'(INIT_FREE);
	// entry 0 reads as its reset value until first written
	assign f      = (frd_zero_q && !e0_q) ? init_e : frd_q;
	assign hdr    = off_q - HDR;
	assign idx_p1 = idx_q + IXW'(1);

	assign fin = (cmd.op == ffha_pkg::OP_ERR) || (cmd.op == ffha_pkg::OP_ASPLIT) ||
		(cmd.op == ffha_pkg::OP_SHFIN) || (cmd.op == ffha_pkg::OP_MPREV) ||
		(cmd.op == ffha_pkg::OP_MNEXT) || (cmd.op == ffha_pkg::OP_INS);
	assign free_ok = (cmd.op == ffha_pkg::OP_MBOTH) || (cmd.op == ffha_pkg::OP_MPREV) ||
		(cmd.op == ffha_pkg::OP_MNEXT) || (cmd.op == ffha_pkg::OP_INSPREP);

	// status flags
	always_comb begin
		flags.is_free    = opfree_q;
		flags.req_zero   = reqz_q;
		flags.live_end   = (idx_q == IXW'(MAX_LIVE_ALLOCS));
		flags.slot_open  = !live_valid_q[idx_q[LAW-1:0]];
		flags.slot_valid = live_valid_q[idx_q[LAW-1:0]];
		flags.free_end   = (idx_q == IXW'(count_q));
		flags.fit        = ({2'b00, f.len} >= aligned_q);
		flags.split      = ({3'b000, f.len} >= ({1'b0, aligned_q} + (SW + 2)'(24)));
		flags.live_hit   = (lrd_q.start == off_q);
		flags.pos_hit    = (f.start >= hdr);
		flags.merge_prev = (idx_q != '0) &&
			(({1'b0, prev_q.start} + HDR_S + {1'b0, prev_q.len}) == {1'b0, hdr});
		flags.merge_next = (idx_q < IXW'(count_q)) &&
			(({1'b0, hdr} + HDR_S + {1'b0, live_len_q}) == {1'b0, cur_q.start});
		flags.table_full = (count_q == FCW'(MAX_FREE_EXTENTS));
		flags.shift_last = (idx_p1 >= IXW'(count_q));
		flags.up_done    = (IXW'(jdx_q) == idx_q);
	end

	// free table port selection
	always_comb begin
		fr_addr = idx_q[FAW-1:0];
		fw_en   = 1'b0;
		fw_addr = idx_q[FAW-1:0];
		fw_data = f;
		case (cmd.op)
			ffha_pkg::OP_SHRD: fr_addr = idx_p1[FAW-1:0];
			ffha_pkg::OP_URD:  fr_addr = FAW'(jdx_q - FCW'(1));
			ffha_pkg::OP_ASPLIT: begin
				fw_en         = 1'b1;
				fw_data.start = f.start + HDR + aligned_q[OW-1:0];
				fw_data.len   = f.len - aligned_q[OW-1:0] - HDR;
			end
			ffha_pkg::OP_SHWR: fw_en = 1'b1;
			ffha_pkg::OP_MBOTH: begin
				fw_en         = 1'b1;
				fw_addr       = FAW'(idx_q - IXW'(1));
				fw_data.start = prev_q.start;
				fw_data.len   = prev_q.len + HDR + live_len_q + HDR + cur_q.len;
			end
			ffha_pkg::OP_MPREV: begin
				fw_en         = 1'b1;
				fw_addr       = FAW'(idx_q - IXW'(1));
				fw_data.start = prev_q.start;
				fw_data.len   = prev_q.len + HDR + live_len_q;
			end
			ffha_pkg::OP_MNEXT: begin
				fw_en         = 1'b1;
				fw_data.start = hdr;
				fw_data.len   = live_len_q + HDR + cur_q.len;
			end
			ffha_pkg::OP_UWR: begin
				fw_en   = 1'b1;
				fw_addr = jdx_q[FAW-1:0];
			end
			ffha_pkg::OP_INS: begin
				fw_en         = 1'b1;
				fw_data.start = hdr;
				fw_data.len   = live_len_q;
			end
			default: ;
		endcase
	end

	// live table write on a grant
	assign lw_en         = (cmd.op == ffha_pkg::OP_ASPLIT) || (cmd.op == ffha_pkg::OP_ATAKE);
	assign lw_data.start = f.start + HDR;
	assign lw_data.len   = (cmd.op == ffha_pkg::OP_ASPLIT) ? aligned_q[OW-1:0] : f.len;

	always_ff @(posedge clk) begin
		if (fw_en) fmem[fw_addr] <= fw_data;
		frd_q      <= fmem[fr_addr];
		frd_zero_q <= (fr_addr == '0);
	end

	always_ff @(posedge clk) begin
		if (lw_en) lmem[slot_q] <= lw_data;
		lrd_q <= lmem[idx_q[LAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_valid_q <= '0;
			count_q      <= FCW'(1);
			total_q      <= SW'(INIT_FREE);
			e0_q         <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= fin;
			if (fw_en && fw_addr == '0) e0_q <= 1'b1;
			if (lw_en) live_valid_q[slot_q] <= 1'b1;
			if (free_ok) live_valid_q[slot_q] <= 1'b0;
			case (cmd.op)
				ffha_pkg::OP_ASPLIT: total_q <= total_q - aligned_q[SW-1:0] - HDR_S;
				ffha_pkg::OP_ATAKE:  total_q <= total_q - {1'b0, f.len};
				ffha_pkg::OP_SHFIN:  count_q <= count_q - FCW'(1);
				ffha_pkg::OP_MBOTH:  total_q <= total_q + {1'b0, live_len_q} + HDR_S + HDR_S;
				ffha_pkg::OP_MPREV,
				ffha_pkg::OP_MNEXT:  total_q <= total_q + {1'b0, live_len_q} + HDR_S;
				ffha_pkg::OP_INS: begin
					total_q <= total_q + {1'b0, live_len_q};
					count_q <= count_q + FCW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_LOAD: begin
				opfree_q  <= opcode;
				reqz_q    <= (request_size == '0);
				aligned_q <= ({1'b0, request_size} + (SW + 1)'(7)) & ~(SW + 1)'(7);
				off_q     <= release_offset;
				idx_q     <= '0;
			end
			ffha_pkg::OP_ERR: begin
				status_q   <= cmd.err;
				res_off_q  <= '0;
				res_size_q <= '0;
			end
			ffha_pkg::OP_NEXT: idx_q <= idx_p1;
			ffha_pkg::OP_SLOT: begin
				slot_q <= idx_q[LAW-1:0];
				idx_q  <= '0;
			end
			ffha_pkg::OP_ASPLIT: begin
				status_q   <= ffha_pkg::ST_OK;
				res_off_q  <= f.start + HDR;
				res_size_q <= aligned_q[SW-1:0];
			end
			ffha_pkg::OP_ATAKE: begin
				status_q   <= ffha_pkg::ST_OK;
				res_off_q  <= f.start + HDR;
				res_size_q <= {1'b0, f.len};
			end
			ffha_pkg::OP_SHWR: idx_q <= idx_p1;
			ffha_pkg::OP_LHIT: begin
				slot_q     <= idx_q[LAW-1:0];
				live_len_q <= lrd_q.len;
				idx_q      <= '0;
			end
			ffha_pkg::OP_PREV: begin
				prev_q <= f;
				idx_q  <= idx_p1;
			end
			ffha_pkg::OP_POSHIT: cur_q <= f;
			ffha_pkg::OP_MBOTH, ffha_pkg::OP_MPREV, ffha_pkg::OP_MNEXT,
			ffha_pkg::OP_INSPREP: begin
				status_q   <= ffha_pkg::ST_OK;
				res_off_q  <= off_q;
				res_size_q <= {1'b0, live_len_q};
				jdx_q      <= count_q;
			end
			ffha_pkg::OP_UWR: jdx_q <= jdx_q - FCW'(1);
			default: ;
		endcase
	end

	assign done           = done_q;
	assign status         = status_q;
	assign payload_offset = res_off_q;
	assign granted_size   = res_size_q;
	assign free_bytes     = total_q;

endmodule

### tb/first_fit_heap_allocator_tb.sv
// testbench for the first-fit heap allocator: directed and random allocate/free
// items checked against an in-bench model of the free and live tables
// depends on ffha_pkg and first_fit_heap_allocator
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

	localparam int NFREE = 256;
	localparam int NLIVE = 256;
	localparam longint ARENA = 64'd4096 * 64'd8192;
	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;
	localparam longint CYCLE_LIMIT = 64'd20000000;

	typedef struct {
		ffha_pkg::status_t st;
		ffha_pkg::off_t    off;
		ffha_pkg::size_t   sz;
		ffha_pkg::size_t   fb;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = OPC_ALLOC;
	logic [25:0] request_size = '0;
	logic [24:0] release_offset = '0;
	logic done;
	logic [2:0] status;
	logic [24:0] payload_offset;
	logic [25:0] granted_size;
	logic [25:0] free_bytes;

	// model state of the arena
	longint ext_hdr [NFREE];
	longint ext_len [NFREE];
	int     ext_cnt;
	longint own_off [NLIVE];
	longint own_len [NLIVE];
	bit     own_ok  [NLIVE];
	longint avail_total;

	heap_result_t pending_results[$];
	int  errors = 0;
	int  send_idle_pct = 0;
	longint cycles = 0;

	always #6 clk = ~clk;

	first_fit_heap_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.request_size(request_size), .release_offset(release_offset), .done(done),
		.status(status), .payload_offset(payload_offset),
		.granted_size(granted_size), .free_bytes(free_bytes)
	);

	function automatic void heap_init();
		ext_cnt = 1;
		ext_hdr[0] = 0;
		ext_len[0] = ARENA - 16;
		for (int i = 0; i < NLIVE; i++) own_ok[i] = 0;
		avail_total = ARENA - 16;
	endfunction

	function automatic void drop_extent(int i);
		for (int k = i; k + 1 < ext_cnt; k++) begin
			ext_hdr[k] = ext_hdr[k+1];
			ext_len[k] = ext_len[k+1];
		end
		ext_cnt--;
	endfunction

	function automatic heap_result_t make_res(ffha_pkg::status_t st, longint off,
			longint sz);
		heap_result_t r;
		r.st = st;
		r.off = ffha_pkg::off_t'(off);
		r.sz = ffha_pkg::size_t'(sz);
		r.fb = ffha_pkg::size_t'(avail_total);
		return r;
	endfunction

	// computes the expected result of one item and updates the model tables
	function automatic heap_result_t heap_predict(logic opc, logic [25:0] req,
			logic [24:0] roff);
		longint aligned, h, g, len;
		int slot, i, pos;
		bit mp, mn;
		if (opc == OPC_ALLOC) begin
			if (req == 0) return make_res(ffha_pkg::ST_ZERO_SIZE, 0, 0);
			aligned = (longint'(req) + 7) & ~64'd7;
			for (slot = 0; slot < NLIVE; slot++) if (!own_ok[slot]) break;
			if (slot >= NLIVE) return make_res(ffha_pkg::ST_LIVE_FULL, 0, 0);
			for (i = 0; i < ext_cnt; i++) if (ext_len[i] >= aligned) break;
			if (i >= ext_cnt) return make_res(ffha_pkg::ST_NO_MEMORY, 0, 0);
			h = ext_hdr[i];
			if (ext_len[i] >= aligned + 24) begin
				ext_hdr[i] = h + 16 + aligned;
				ext_len[i] = ext_len[i] - aligned - 16;
				g = aligned;
				avail_total -= aligned + 16;
			end else begin
				g = ext_len[i];
				avail_total -= g;
				drop_extent(i);
			end
			own_ok[slot] = 1;
			own_off[slot] = h + 16;
			own_len[slot] = g;
			return make_res(ffha_pkg::ST_OK, h + 16, g);
		end
		for (slot = 0; slot < NLIVE; slot++)
			if (own_ok[slot] && own_off[slot] == longint'(roff)) break;
		if (slot >= NLIVE) return make_res(ffha_pkg::ST_UNKNOWN, 0, 0);
		len = own_len[slot];
		h = longint'(roff) - 16;
		for (pos = 0; pos < ext_cnt; pos++) if (ext_hdr[pos] >= h) break;
		mp = pos > 0 && ext_hdr[pos-1] + 16 + ext_len[pos-1] == h;
		mn = pos < ext_cnt && h + 16 + len == ext_hdr[pos];
		if (mp && mn) begin
			ext_len[pos-1] += 32 + len + ext_len[pos];
			drop_extent(pos);
			avail_total += len + 32;
		end else if (mp) begin
			ext_len[pos-1] += 16 + len;
			avail_total += len + 16;
		end else if (mn) begin
			ext_hdr[pos] = h;
			ext_len[pos] = len + 16 + ext_len[pos];
			avail_total += len + 16;
		end else begin
			if (ext_cnt >= NFREE) return make_res(ffha_pkg::ST_FREE_FULL, 0, 0);
			for (i = ext_cnt; i > pos; i--) begin
				ext_hdr[i] = ext_hdr[i-1];
				ext_len[i] = ext_len[i-1];
			end
			ext_hdr[pos] = h;
			ext_len[pos] = len;
			ext_cnt++;
			avail_total += len;
		end
		own_ok[slot] = 0;
		return make_res(ffha_pkg::ST_OK, roff, len);
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	// result checker: every done strobe is matched against the oldest expectation
	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d off=%0d", $time, status,
					payload_offset);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || payload_offset !== e.off ||
						granted_size !== e.sz || free_bytes !== e.fb) begin
					$display("%0t: mismatch expected st=%0d off=%0d sz=%0d fb=%0d",
						$time, e.st, e.off, e.sz, e.fb);
					$display("%0t:          actual   st=%0d off=%0d sz=%0d fb=%0d",
						$time, status, payload_offset, granted_size, free_bytes);
					errors++;
				end
			end
		end
	end

	// sends one item, with a random idle gap before it in the idling phases
	task automatic send_item(logic opc, logic [25:0] req, logic [24:0] roff);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b1;
		opcode <= opc;
		request_size <= req;
		release_offset <= roff;
		pending_results.push_back(heap_predict(opc, req, roff));
		@(posedge clk);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// picks a random live payload offset, or a random bogus one if none is live
	function automatic logic [24:0] pick_live();
		int n;
		n = 0;
		for (int i = 0; i < NLIVE; i++) if (own_ok[i]) n++;
		if (n == 0) return 25'($urandom);
		n = $urandom_range(n - 1);
		for (int i = 0; i < NLIVE; i++)
			if (own_ok[i]) begin
				if (n == 0) return 25'(own_off[i]);
				n--;
			end
		return '0;
	endfunction

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(OPC_ALLOC, 26'd0, '1);
		send_item(OPC_ALLOC, 26'h3FFFFFF, '0);
		send_item(OPC_ALLOC, 26'd33554432, '0);
		send_item(OPC_FREE, '1, 25'd16);
		send_item(OPC_FREE, '0, 25'h1FFFFFF);
		send_item(OPC_ALLOC, 26'd1, '0);
		send_item(OPC_ALLOC, 26'd8, '0);
		send_item(OPC_ALLOC, 26'd9, '0);
		send_item(OPC_ALLOC, 26'd100, '0);
		send_item(OPC_FREE, '0, 25'd32);
		send_item(OPC_FREE, '0, 25'd32);
		send_item(OPC_FREE, '0, 25'd56);
		send_item(OPC_FREE, '0, 25'd16);
		send_item(OPC_FREE, '0, 25'd80);
		// whole arena in one item, then release it
		send_item(OPC_ALLOC, 26'(ARENA - 16), '0);
		send_item(OPC_FREE, '0, 25'd16);
		drain();
	endtask

	// carves small blocks until it runs into the live table limit, then frees every
	// other one to grow the free table, and then the rest
	task automatic test_table_limits();
		for (int i = 0; i < NLIVE + 2; i++) send_item(OPC_ALLOC, 26'($urandom_range(1, 40)), '0);
		for (int i = 0; i < NLIVE; i += 2)
			if (own_ok[i]) send_item(OPC_FREE, '0, 25'(own_off[i]));
		for (int i = 1; i < NLIVE; i += 2)
			if (own_ok[i]) send_item(OPC_FREE, '0, 25'(own_off[i]));
		drain();
	endtask

	task automatic test_random(int n, int idle_pct);
		int r;
		send_idle_pct = idle_pct;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 45) send_item(OPC_ALLOC, 26'($urandom_range(1, 300)), 25'($urandom));
			else if (r < 50) send_item(OPC_ALLOC, 26'($urandom), 25'($urandom));
			else if (r < 52) send_item(OPC_ALLOC, 26'd0, 25'($urandom));
			else if (r < 92) send_item(OPC_FREE, 26'($urandom), pick_live());
			else send_item(OPC_FREE, 26'($urandom), 25'($urandom));
		end
		send_idle_pct = 0;
	endtask

	initial begin
		heap_init();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_limits();
		test_random(125, 0);
		// pause until the block has answered everything, then continue
		drain();
		test_random(125, 70);
		test_random(125, 0);
		test_random(125, 21);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
